// ===== sv/robin_hood_hash_table_top_defines.svh =====
// Assertion macros shared by the checker of the robin-hood hash table.
// Depends on a clock named aclk and an active-low reset named aresetn in scope.
`ifndef ROBIN_HOOD_HASH_TABLE_TOP_DEFINES_SVH
`define ROBIN_HOOD_HASH_TABLE_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RH_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define RH_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/rh_pkg.sv =====
// Package of the robin-hood hash table: request and status codes, hash constants
// and default sizes. No dependencies.
`default_nettype none
package rh_pkg;
    localparam int CAPACITY_DEF   = 256;
    localparam int VALUE_BITS_DEF = 32;

    localparam int KEY_W    = 32;
    localparam int REQ_W    = 3;
    localparam int STATUS_W = 2;
    localparam int FVAL_W   = 32;
    localparam int SLOT_W   = 8;
    localparam int LIMIT_W  = 9;
    localparam int LONG_W   = 9;

    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 48;

    localparam logic [LIMIT_W-1:0] FILL_LIMIT_RESET = 9'd192;
    localparam logic [LONG_W-1:0]  PROBE_MAX        = 9'd511;
    localparam logic [KEY_W-1:0]   HASH_XOR         = 32'd61;
    localparam logic [KEY_W-1:0]   HASH_MUL         = 32'h27d4eb2d;

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT = 3'd0,
        REQ_UNIQUE = 3'd1,
        REQ_LOOKUP = 3'd2,
        REQ_ERASE  = 3'd3,
        REQ_CLEAR  = 3'd4
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE     = 2'd0,
        ST_FOUND    = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } status_t;
endpackage
`default_nettype wire

// ===== sv/robin_hood_hash_table_top.sv =====
// Robin-hood hash table of 32-bit keys. Each request yields one result beat.
// After reset the block sweeps all CAPACITY entries before taking requests; a
// clear request sweeps them again the same way. Any other request hashes the key
// and then probes slot by slot, since every probed slot is read and evaluated
// through the single entry memory and written back only where it changes.
// Insert-if-unique that misses pays for the search and then the insert.
`default_nettype none
module robin_hood_hash_table_top #(
    parameter int CAPACITY   = rh_pkg::CAPACITY_DEF,
    parameter int VALUE_BITS = rh_pkg::VALUE_BITS_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    // req_type[2:0], key[34:3], value[66:35], zero pad
    input  wire logic [rh_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    // status[1:0], found_value[33:2], slot[41:34], zero pad
    output logic      [rh_pkg::M_TDATA_W-1:0] m_tdata,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [rh_pkg::LIMIT_W-1:0]   cfg_data
);
    import rh_pkg::*;

    localparam int SW   = $clog2(CAPACITY);
    localparam int CNW  = SW + 1;
    localparam int PRW  = (SW + 1 > 10) ? SW + 1 : 10;
    localparam int CMPW = (CNW > LIMIT_W) ? CNW : LIMIT_W;
    localparam int EW   = 1 + SW + KEY_W + VALUE_BITS;

    typedef enum logic [8:0] {
        S_INIT  = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_HASH1 = 9'b000000100,
        S_HASH2 = 9'b000001000,
        S_START = 9'b000010000,
        S_READ  = 9'b000100000,
        S_EVAL  = 9'b001000000,
        S_CLEAR = 9'b010000000,
        S_DONE  = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    req_t   op_reg, op_next;
    logic [KEY_W-1:0]      key_reg, key_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic [SW-1:0]         home_reg, home_next;
    logic [SW-1:0]         idx_reg, idx_next;
    logic [SW-1:0]         placed_reg, placed_next;
    logic                  have_reg, have_next;
    logic                  ins_reg, ins_next;
    logic [PRW-1:0]        probe_reg, probe_next;
    logic [CNW-1:0]        count_reg, count_next;
    logic [LONG_W-1:0]     long_reg, long_next;
    logic [LIMIT_W-1:0]    fill_reg, fill_next;
    status_t               rstat_reg, rstat_next;
    logic [FVAL_W-1:0]     rfval_reg, rfval_next;
    logic [SLOT_W-1:0]     rslot_reg, rslot_next;
    logic                  mv_reg, mv_next;
    logic [M_TDATA_W-1:0]  md_reg, md_next;

    logic [SW-1:0]         hash_home;
    logic                  mem_we;
    logic [EW-1:0]         mem_wdata;
    logic [EW-1:0]         rd;
    logic                  cur_occ;
    logic [SW-1:0]         cur_home;
    logic [KEY_W-1:0]      cur_key;
    logic [VALUE_BITS-1:0] cur_val;
    logic                  full;
    logic [SW-1:0]         home_gap;
    logic [PRW-1:0]        pbase;
    logic [PRW-1:0]        pinc;
    logic                  swap;

    rh_hash #(.SW(SW)) u_hash (
        .aclk  (aclk),
        .key_i (key_reg),
        .home_o(hash_home)
    );

    rh_mem #(.DEPTH(CAPACITY), .AW(SW), .DW(EW)) u_mem (
        .aclk (aclk),
        .we   (mem_we),
        .waddr(idx_reg),
        .wdata(mem_wdata),
        .raddr(idx_reg),
        .rdata(rd)
    );

    assign cur_occ  = rd[EW-1];
    assign cur_home = rd[EW-2 -: SW];
    assign cur_key  = rd[VALUE_BITS +: KEY_W];
    assign cur_val  = rd[VALUE_BITS-1:0];

    assign full = (CMPW'(count_reg) >= CMPW'(fill_reg)) ||
                  (CMPW'(count_reg) >= CMPW'(CAPACITY));
    assign home_gap = idx_reg - cur_home;
    assign swap     = PRW'(home_gap) < probe_reg;
    assign pbase    = swap ? PRW'(home_gap) : probe_reg;
    assign pinc     = (ins_reg ? pbase : probe_reg) + PRW'(1);

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = mv_reg;
    assign m_tdata   = md_reg;

    always_comb begin
        state_next  = state_reg;
        op_next     = op_reg;
        key_next    = key_reg;
        val_next    = val_reg;
        home_next   = home_reg;
        idx_next    = idx_reg;
        placed_next = placed_reg;
        have_next   = have_reg;
        ins_next    = ins_reg;
        probe_next  = probe_reg;
        count_next  = count_reg;
        long_next   = long_reg;
        fill_next   = fill_reg;
        rstat_next  = rstat_reg;
        rfval_next  = rfval_reg;
        rslot_next  = rslot_reg;
        mv_next     = mv_reg;
        md_next     = md_reg;
        mem_we      = 1'b0;
        mem_wdata   = '0;

        if (cfg_valid && cfg_ready) begin
            fill_next = cfg_data;
        end
        if (mv_reg && m_tready) begin
            mv_next = 1'b0;
        end

        unique case (state_reg)
            S_INIT: begin
                mem_we   = 1'b1;
                idx_next = idx_reg + SW'(1);
                if (idx_reg == SW'(CAPACITY - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next    = req_t'(s_tdata[2:0]);
                    key_next   = s_tdata[34:3];
                    val_next   = VALUE_BITS'(s_tdata[66:35]);
                    state_next = S_HASH1;
                end
            end
            S_HASH1: state_next = S_HASH2;
            S_HASH2: state_next = S_START;
            S_START: begin
                home_next  = hash_home;
                idx_next   = hash_home;
                probe_next = '0;
                have_next  = 1'b0;
                rfval_next = '0;
                rslot_next = '0;
                case (op_reg) inside
                    REQ_INSERT, REQ_UNIQUE, REQ_LOOKUP, REQ_ERASE: begin
                        if (op_reg == REQ_INSERT ||
                            (op_reg == REQ_UNIQUE && count_reg == '0)) begin
                            if (full) begin
                                rstat_next = ST_FULL;
                                state_next = S_DONE;
                            end else begin
                                ins_next   = 1'b1;
                                state_next = S_READ;
                            end
                        end else if (count_reg == '0) begin
                            rstat_next = ST_NOTFOUND;
                            state_next = S_DONE;
                        end else begin
                            ins_next   = 1'b0;
                            state_next = S_READ;
                        end
                    end
                    REQ_CLEAR: begin
                        idx_next   = '0;
                        count_next = '0;
                        long_next  = '0;
                        rstat_next = ST_DONE;
                        state_next = S_CLEAR;
                    end
                    default: begin
                        rstat_next = ST_NOTFOUND;
                        state_next = S_DONE;
                    end
                endcase
            end
            S_READ: state_next = S_EVAL;
            S_EVAL: begin
                if (!ins_reg) begin
                    if (cur_occ && cur_key == key_reg) begin
                        rfval_next = FVAL_W'(cur_val);
                        rslot_next = SLOT_W'(idx_reg);
                        rstat_next = ST_FOUND;
                        state_next = S_DONE;
                        if (op_reg == REQ_ERASE) begin
                            mem_we     = 1'b1;
                            mem_wdata  = {1'b0, rd[EW-2:0]};
                            count_next = count_reg - CNW'(1);
                            rstat_next = ST_DONE;
                        end
                    end else if (pinc > PRW'(long_reg)) begin
                        if (op_reg == REQ_UNIQUE) begin
                            if (full) begin
                                rstat_next = ST_FULL;
                                state_next = S_DONE;
                            end else begin
                                ins_next   = 1'b1;
                                idx_next   = home_reg;
                                probe_next = '0;
                                state_next = S_READ;
                            end
                        end else begin
                            rstat_next = ST_NOTFOUND;
                            state_next = S_DONE;
                        end
                    end else begin
                        probe_next = pinc;
                        idx_next   = idx_reg + SW'(1);
                        state_next = S_READ;
                    end
                end else if (!cur_occ) begin
                    mem_we     = 1'b1;
                    mem_wdata  = {1'b1, home_reg, key_reg, val_reg};
                    count_next = count_reg + CNW'(1);
                    rstat_next = ST_DONE;
                    rslot_next = SLOT_W'(have_reg ? placed_reg : idx_reg);
                    state_next = S_DONE;
                end else begin
                    if (swap) begin
                        mem_we    = 1'b1;
                        mem_wdata = {1'b1, home_reg, key_reg, val_reg};
                        key_next  = cur_key;
                        val_next  = cur_val;
                        home_next = cur_home;
                        if (!have_reg) begin
                            placed_next = idx_reg;
                            have_next   = 1'b1;
                        end
                    end
                    probe_next = pinc;
                    idx_next   = idx_reg + SW'(1);
                    if (pinc > PRW'(long_reg)) begin
                        long_next = (pinc > PRW'(PROBE_MAX)) ? PROBE_MAX : pinc[LONG_W-1:0];
                    end
                    state_next = S_READ;
                end
            end
            S_CLEAR: begin
                mem_we   = 1'b1;
                idx_next = idx_reg + SW'(1);
                if (idx_reg == SW'(CAPACITY - 1)) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!mv_reg || m_tready) begin
                    mv_next    = 1'b1;
                    md_next    = {6'd0, rslot_reg, rfval_reg, rstat_reg};
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_INIT;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
            idx_reg   <= '0;
            count_reg <= '0;
            long_reg  <= '0;
            fill_reg  <= FILL_LIMIT_RESET;
            mv_reg    <= 1'b0;
            ins_reg   <= 1'b0;
            have_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            count_reg <= count_next;
            long_reg  <= long_next;
            fill_reg  <= fill_next;
            mv_reg    <= mv_next;
            ins_reg   <= ins_next;
            have_reg  <= have_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        key_reg    <= key_next;
        val_reg    <= val_next;
        home_reg   <= home_next;
        placed_reg <= placed_next;
        probe_reg  <= probe_next;
        rstat_reg  <= rstat_next;
        rfval_reg  <= rfval_next;
        rslot_reg  <= rslot_next;
        md_reg     <= md_next;
    end
endmodule
`default_nettype wire

// ===== sv/rh_hash.sv =====
// Two-stage key mixer giving the home bucket of a key.
// Depends on rh_pkg for the mixing constants.
`default_nettype none
module rh_hash #(
    parameter int SW = 8
) (
    input  wire logic                 aclk,
    input  wire logic [rh_pkg::KEY_W-1:0] key_i,
    output logic      [SW-1:0]        home_o
);
    import rh_pkg::*;

    logic [KEY_W-1:0] pre_a;
    logic [KEY_W-1:0] pre_b;
    logic [KEY_W-1:0] pre_c;
    logic [KEY_W-1:0] mix_reg;
    logic [KEY_W-1:0] prod_reg;
    logic [KEY_W-1:0] final_w;

    assign pre_a = (key_i ^ HASH_XOR) ^ (key_i >> 16);
    assign pre_b = pre_a + (pre_a << 3);
    assign pre_c = pre_b ^ (pre_b >> 4);

    always_ff @(posedge aclk) begin
        mix_reg  <= pre_c;
        prod_reg <= mix_reg * HASH_MUL;
    end

    assign final_w = prod_reg ^ (prod_reg >> 15);
    assign home_o  = final_w[SW-1:0];
endmodule
`default_nettype wire

// ===== sv/rh_mem.sv =====
// Entry memory: one write port and one read port with registered read data.
// No dependencies.
`default_nettype none
module rh_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int DW    = 73
) (
    input  wire logic          aclk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata
);
    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== sv/rh_checker.sv =====
// Port-level checker of the robin-hood hash table, bound to the top level.
// Depends on rh_pkg and robin_hood_hash_table_top_defines.svh.
`default_nettype none
`include "robin_hood_hash_table_top_defines.svh"
module rh_checker (
    input wire logic                         aclk,
    input wire logic                         aresetn,
    input wire logic                         m_tvalid,
    input wire logic                         m_tready,
    input wire logic [rh_pkg::M_TDATA_W-1:0] m_tdata
);
    import rh_pkg::*;

    `RH_ASSERT_NXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled beat changed")
    `RH_ASSERT_IMP(a_full, m_tvalid && m_tdata[1:0] == ST_FULL, m_tdata[41:2] == '0, "full beat carries data")
    `RH_ASSERT_IMP(a_miss, m_tvalid && m_tdata[1:0] == ST_NOTFOUND, m_tdata[41:2] == '0, "miss beat carries data")
    `RH_ASSERT_IMP(a_pad, m_tvalid, m_tdata[47:42] == '0, "pad bits not zero")
endmodule

bind robin_hood_hash_table_top rh_checker u_rh_checker (.*);
`default_nettype wire
